>>> rtl/core/pap_pkg.sv
`default_nettype none

package pap_pkg;

  // Default sizing
  localparam int NUM_SITES_DEF  = 16;
  localparam int COUNT_BITS_DEF = 32;

  // Fixed field widths
  localparam int SITE_W    = 4;
  localparam int ADDR_W    = 64;
  localparam int OUT_W     = 32;
  localparam int PROB_W    = 17;
  localparam int FRAC_BITS = 16;
  localparam logic [PROB_W-1:0] ONE_Q16 = 17'h10000;

  // Front queue depth
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [0:0] {
    OP_RECORD = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  // Decoded item as held in the queue
  typedef struct packed {
    op_t               op;
    logic [SITE_W-1:0] first_site;
    logic [SITE_W-1:0] second_site;
    logic [ADDR_W-1:0] address;
    logic              first_ok;
    logic              second_ok;
  } item_t;

  // Back-to-front control
  typedef struct packed {
    logic clearing;
    logic pop;
  } back_ctl_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_QWAIT,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [OUT_W-1:0]  comparisons;
    logic [OUT_W-1:0]  collisions;
    logic [PROB_W-1:0] probability;
    logic              same_site;
    logic              not_found;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/pap_ram.sv
`default_nettype none

module pap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                            clk,
  input  wire                            we,
  input  wire [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  wire [WIDTH-1:0]                wdata,
  input  wire [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/pap_front.sv
`default_nettype none

module pap_front #(
  parameter int NUM_SITES = pap_pkg::NUM_SITES_DEF
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         item_valid,
  output logic                        item_stall,
  input  wire                         op,
  input  wire [pap_pkg::SITE_W-1:0]   first_site,
  input  wire [pap_pkg::ADDR_W-1:0]   address,
  input  wire [pap_pkg::SITE_W-1:0]   second_site,
  input  pap_pkg::back_ctl_t          ctl,
  output pap_pkg::item_t              head,
  output logic                        head_valid
);

  localparam int PTR_W = $clog2(pap_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(pap_pkg::QUEUE_DEPTH + 1);

  pap_pkg::item_t    entry [pap_pkg::QUEUE_DEPTH];
  pap_pkg::item_t    decoded;
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  // Classify the incoming item: op and site range checks
  always_comb begin
    decoded.op          = pap_pkg::op_t'(op);
    decoded.first_site  = first_site;
    decoded.second_site = second_site;
    decoded.address     = address;
    decoded.first_ok    = (9'(first_site) < 9'(NUM_SITES));
    decoded.second_ok   = (9'(second_site) < 9'(NUM_SITES));
  end

  assign item_stall = ctl.clearing || (count == CNT_W'(pap_pkg::QUEUE_DEPTH));
  assign push       = item_valid && !item_stall;
  assign pop        = ctl.pop && head_valid;
  assign head_valid = (count != '0);
  assign head       = entry[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= decoded;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(pap_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(pap_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pap_back.sv
`default_nettype none

module pap_back #(
  parameter int NUM_SITES  = pap_pkg::NUM_SITES_DEF,
  parameter int COUNT_BITS = pap_pkg::COUNT_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  pap_pkg::item_t      head,
  input  wire                 head_valid,
  output pap_pkg::back_ctl_t  ctl,
  output logic                result_valid,
  input  wire                 result_stall,
  output pap_pkg::result_t    result
);

  localparam int SW     = $clog2(NUM_SITES);
  localparam int PAIRS  = NUM_SITES * (NUM_SITES - 1) / 2;
  localparam int PW     = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int CB     = COUNT_BITS;
  localparam int STEP_W = $clog2(pap_pkg::FRAC_BITS);

  pap_pkg::state_t   state;
  pap_pkg::state_t   state_next;
  logic [SW-1:0]     k;
  logic [SW-1:0]     cur_site;
  logic [pap_pkg::ADDR_W-1:0] cur_addr;
  logic [NUM_SITES-1:0] seen;
  logic              pipe_v;
  logic [PW-1:0]     pipe_slot;
  logic [PW-1:0]     clr_idx;
  logic [CB-1:0]     cmp_reg;
  logic [CB-1:0]     rem;
  logic [pap_pkg::PROB_W-1:0] quo;
  logic [STEP_W-1:0] step;
  pap_pkg::result_t  res;

  // RAM ports
  logic                       addr_we;
  logic [SW-1:0]              addr_raddr;
  logic [pap_pkg::ADDR_W-1:0] addr_rdata;
  logic                       ctr_we;
  logic [PW-1:0]              ctr_waddr;
  logic [2*CB-1:0]            ctr_wdata;
  logic [PW-1:0]              ctr_raddr;
  logic [2*CB-1:0]            ctr_rdata;

  logic [SW-1:0]  head_a;
  logic [SW-1:0]  head_b;
  logic [CB-1:0]  rd_cmp;
  logic [CB-1:0]  rd_col;
  logic [CB-1:0]  upd_cmp;
  logic [CB-1:0]  upd_col;
  logic [CB:0]    rem_dbl;
  logic           rem_ge;
  logic           last_k;
  logic           take;

  // Unordered pair index: hi*(hi-1)/2 + lo
  function automatic logic [PW-1:0] slot_of(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [SW-1:0]   lo;
    logic [SW-1:0]   hi;
    logic [2*SW-1:0] prod;
    lo   = (a < b) ? a : b;
    hi   = (a < b) ? b : a;
    prod = (2*SW)'(hi) * (2*SW)'(hi - 1'b1);
    return PW'(prod >> 1) + PW'(lo);
  endfunction

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [pap_pkg::OUT_W-1:0] clip(input logic [CB-1:0] v);
    logic [63:0] e;
    e = 64'(v);
    return (|e[63:32]) ? '1 : e[31:0];
  endfunction

  assign head_a  = SW'(head.first_site);
  assign head_b  = SW'(head.second_site);
  assign rd_cmp  = ctr_rdata[2*CB-1:CB];
  assign rd_col  = ctr_rdata[CB-1:0];
  assign upd_cmp = sat_inc(rd_cmp);
  assign upd_col = (addr_rdata == cur_addr) ? sat_inc(rd_col) : rd_col;
  assign rem_dbl = {rem, 1'b0};
  assign rem_ge  = (rem_dbl >= (CB+1)'(cmp_reg));
  assign last_k  = (k == SW'(NUM_SITES - 1));
  assign take    = (state == pap_pkg::ST_IDLE) && head_valid;

  pap_ram #(.WIDTH(pap_pkg::ADDR_W), .DEPTH(NUM_SITES)) u_addr_ram (
    .clk   (clk),
    .we    (addr_we),
    .waddr (head_a),
    .wdata (head.address),
    .raddr (addr_raddr),
    .rdata (addr_rdata)
  );

  pap_ram #(.WIDTH(2*CB), .DEPTH(PAIRS)) u_ctr_ram (
    .clk   (clk),
    .we    (ctr_we),
    .waddr (ctr_waddr),
    .wdata (ctr_wdata),
    .raddr (ctr_raddr),
    .rdata (ctr_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      pap_pkg::ST_CLEAR: begin
        if (clr_idx == PW'(PAIRS - 1)) state_next = pap_pkg::ST_IDLE;
      end
      pap_pkg::ST_IDLE: begin
        if (head_valid) begin
          if (head.op == pap_pkg::OP_RECORD) begin
            if (head.first_ok) state_next = pap_pkg::ST_SWEEP;
          end else if (head.first_site == head.second_site) begin
            state_next = pap_pkg::ST_OUT;
          end else if (!head.first_ok || !head.second_ok) begin
            state_next = pap_pkg::ST_OUT;
          end else begin
            state_next = pap_pkg::ST_QWAIT;
          end
        end
      end
      pap_pkg::ST_SWEEP: begin
        if (last_k) state_next = pap_pkg::ST_DRAIN;
      end
      pap_pkg::ST_DRAIN: state_next = pap_pkg::ST_IDLE;
      pap_pkg::ST_QWAIT: begin
        state_next = (rd_cmp == '0) ? pap_pkg::ST_OUT : pap_pkg::ST_DIV;
      end
      pap_pkg::ST_DIV: begin
        if (step == STEP_W'(pap_pkg::FRAC_BITS - 1)) state_next = pap_pkg::ST_OUT;
      end
      pap_pkg::ST_OUT: begin
        if (!result_stall) state_next = pap_pkg::ST_IDLE;
      end
      default: state_next = pap_pkg::ST_IDLE;
    endcase
  end

  // Outputs and memory controls
  always_comb begin
    ctl.clearing = (state == pap_pkg::ST_CLEAR);
    ctl.pop      = take;
    result_valid = (state == pap_pkg::ST_OUT);
    result       = res;
    addr_we      = take && (head.op == pap_pkg::OP_RECORD) && head.first_ok;
    addr_raddr   = k;
    ctr_raddr    = (state == pap_pkg::ST_SWEEP) ? slot_of(cur_site, k) : slot_of(head_a, head_b);
    if (state == pap_pkg::ST_CLEAR) begin
      ctr_we    = 1'b1;
      ctr_waddr = clr_idx;
      ctr_wdata = '0;
    end else begin
      ctr_we    = pipe_v;
      ctr_waddr = pipe_slot;
      ctr_wdata = {upd_cmp, upd_col};
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pap_pkg::ST_CLEAR;
      clr_idx <= '0;
      seen    <= '0;
      pipe_v  <= 1'b0;
      k       <= '0;
      step    <= '0;
    end else begin
      state  <= state_next;
      pipe_v <= (state == pap_pkg::ST_SWEEP) && seen[k] && (k != cur_site);
      if (state == pap_pkg::ST_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (addr_we) begin
        seen[head_a] <= 1'b1;
        k            <= '0;
      end else if (state == pap_pkg::ST_SWEEP) begin
        k <= k + 1'b1;
      end
      if (state == pap_pkg::ST_QWAIT) step <= '0;
      else if (state == pap_pkg::ST_DIV) step <= step + 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    pipe_slot <= slot_of(cur_site, k);
    if (addr_we) begin
      cur_site <= head_a;
      cur_addr <= head.address;
    end
    // Seed the answer when a query leaves the queue
    if (take && head.op == pap_pkg::OP_QUERY) begin
      if (head.first_site == head.second_site) begin
        res <= {{(2*pap_pkg::OUT_W){1'b0}}, pap_pkg::ONE_Q16, 2'b10};
      end else if (!head.first_ok || !head.second_ok) begin
        res <= {{(2*pap_pkg::OUT_W+pap_pkg::PROB_W){1'b0}}, 2'b01};
      end else begin
        res <= '0;
      end
    end
    // Fetch the pair counts and seed the divider
    if (state == pap_pkg::ST_QWAIT) begin
      if (rd_cmp == '0) begin
        res.not_found <= 1'b1;
      end else begin
        res.comparisons <= clip(rd_cmp);
        res.collisions  <= clip(rd_col);
        cmp_reg         <= rd_cmp;
        quo             <= pap_pkg::PROB_W'(rd_col >= rd_cmp);
        rem             <= (rd_col >= rd_cmp) ? rd_col - rd_cmp : rd_col;
      end
    end
    // One quotient bit per cycle
    if (state == pap_pkg::ST_DIV) begin
      rem <= rem_ge ? CB'(rem_dbl - (CB+1)'(cmp_reg)) : CB'(rem_dbl);
      quo <= {quo[pap_pkg::PROB_W-2:0], rem_ge};
      if (step == STEP_W'(pap_pkg::FRAC_BITS - 1)) begin
        res.probability <= {quo[pap_pkg::PROB_W-2:0], rem_ge};
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/pairwise_alias_profiler_top.sv
// Record: the back end sweeps one site per cycle over the last-address and
// pair-counter memories, plus issue and drain. Query: same-site or out-of-range
// pairs skip the counter read; a compared pair goes through the 16-step divider.
// A two-entry queue decouples input from the back end; one result per query.
// Reset: synchronous; a clearing pass writes N*(N-1)/2 counter rows (120 for
// 16 sites), one per cycle, with item_stall high throughout.
`default_nettype none

module pairwise_alias_profiler_top #(
  parameter int NUM_SITES  = pap_pkg::NUM_SITES_DEF,
  parameter int COUNT_BITS = pap_pkg::COUNT_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          item_valid,
  output logic                         item_stall,
  input  wire                          op,
  input  wire [pap_pkg::SITE_W-1:0]    first_site,
  input  wire [pap_pkg::ADDR_W-1:0]    address,
  input  wire [pap_pkg::SITE_W-1:0]    second_site,
  output logic                         result_valid,
  input  wire                          result_stall,
  output logic [pap_pkg::OUT_W-1:0]    pair_comparisons,
  output logic [pap_pkg::OUT_W-1:0]    pair_collisions,
  output logic [pap_pkg::PROB_W-1:0]   probability,
  output logic                         same_site,
  output logic                         not_found
);

  pap_pkg::back_ctl_t ctl;
  pap_pkg::item_t     head;
  logic               head_valid;
  pap_pkg::result_t   result;

  pap_front #(.NUM_SITES(NUM_SITES)) u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .op          (op),
    .first_site  (first_site),
    .address     (address),
    .second_site (second_site),
    .ctl         (ctl),
    .head        (head),
    .head_valid  (head_valid)
  );

  pap_back #(.NUM_SITES(NUM_SITES), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .ctl          (ctl),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  assign pair_comparisons = result.comparisons;
  assign pair_collisions  = result.collisions;
  assign probability      = result.probability;
  assign same_site        = result.same_site;
  assign not_found        = result.not_found;

endmodule

`default_nettype wire

>>> rtl/core/pap_checker.sv
`default_nettype none

module pap_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          item_stall,
  input wire                          result_valid,
  input wire                          result_stall,
  input wire [pap_pkg::OUT_W-1:0]     pair_comparisons,
  input wire [pap_pkg::OUT_W-1:0]     pair_collisions,
  input wire [pap_pkg::PROB_W-1:0]    probability,
  input wire                          same_site,
  input wire                          not_found
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(probability)
      && $stable(pair_comparisons) && $stable(pair_collisions))
    else $error("stalled result changed");

  // Same-site answers are exactly 1.0 with zero counts
  assert property (@(posedge clk) disable iff (rst)
    result_valid && same_site |-> probability == pap_pkg::ONE_Q16 && !not_found
      && pair_comparisons == '0 && pair_collisions == '0)
    else $error("bad same-site result");

  // Not-found answers (uncompared or out-of-range pairs) carry zero probability and comparisons
  assert property (@(posedge clk) disable iff (rst)
    result_valid && not_found |-> probability == '0 && pair_comparisons == '0)
    else $error("bad not-found result");

  // Compared pairs: nonzero count, collisions bounded by comparisons
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !same_site && !not_found |-> pair_comparisons != '0
      && pair_collisions <= pair_comparisons && probability <= pap_pkg::ONE_Q16)
    else $error("inconsistent pair result");

  // Coming out of reset the block clears first: no transfer either way
  assert property (@(posedge clk) !rst && $past(rst) |-> item_stall && !result_valid)
    else $error("activity right after reset");

endmodule

bind pairwise_alias_profiler_top pap_checker u_pap_checker (
  .clk              (clk),
  .rst              (rst),
  .item_stall       (item_stall),
  .result_valid     (result_valid),
  .result_stall     (result_stall),
  .pair_comparisons (pair_comparisons),
  .pair_collisions  (pair_collisions),
  .probability      (probability),
  .same_site        (same_site),
  .not_found        (not_found)
);

`default_nettype wire

>>> tb/tb_pairwise_alias_profiler_top.sv
`timescale 1ns / 1ps
`default_nettype none

module tb_pairwise_alias_profiler_top;

  localparam int NSITES = 16;
  localparam int NPAIRS = NSITES * (NSITES - 1) / 2;

  typedef struct packed {
    logic [pap_pkg::OUT_W-1:0]  comparisons;
    logic [pap_pkg::OUT_W-1:0]  collisions;
    logic [pap_pkg::PROB_W-1:0] prob;
    logic                       same;
    logic                       missing;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic op = 1'b0;
  logic [pap_pkg::SITE_W-1:0] first_site = '0;
  logic [pap_pkg::ADDR_W-1:0] address = '0;
  logic [pap_pkg::SITE_W-1:0] second_site = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [pap_pkg::OUT_W-1:0] pair_comparisons;
  logic [pap_pkg::OUT_W-1:0] pair_collisions;
  logic [pap_pkg::PROB_W-1:0] probability;
  logic same_site;
  logic not_found;

  pairwise_alias_profiler_top u_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .op(op), .first_site(first_site), .address(address), .second_site(second_site),
    .result_valid(result_valid), .result_stall(result_stall),
    .pair_comparisons(pair_comparisons), .pair_collisions(pair_collisions),
    .probability(probability), .same_site(same_site), .not_found(not_found)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the profiler state
  logic [pap_pkg::ADDR_W-1:0] site_addr [NSITES];
  logic                       site_valid [NSITES];
  logic [31:0]                cmp_cnt [NPAIRS];
  logic [31:0]                col_cnt [NPAIRS];
  answer_t                    answers_pending [$];

  int mismatches = 0;
  int answers_seen = 0;
  int stall_left = 0;
  bit hold_off = 1'b0;
  bit quiet_sink = 1'b0;

  function automatic int pair_index(int a, int b);
    int lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return hi * (hi - 1) / 2 + lo;
  endfunction

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Q1.16 ratio by integer division, collisions never above comparisons
  function automatic logic [pap_pkg::PROB_W-1:0] alias_ratio(logic [31:0] col,
                                                              logic [31:0] cmp);
    logic [48:0] num;
    logic [48:0] quot;
    num  = {1'b0, col, 16'd0};
    quot = num / {17'd0, cmp};
    return quot[pap_pkg::PROB_W-1:0];
  endfunction

  // Update the shadow state for one transfer and queue any answer
  task automatic predict_alias(pap_pkg::op_t o, int sa, logic [pap_pkg::ADDR_W-1:0] addr,
                               int sb);
    answer_t a;
    int p;
    if (o == pap_pkg::OP_RECORD) begin
      site_addr[sa] = addr;
      site_valid[sa] = 1'b1;
      for (int k = 0; k < NSITES; k++) begin
        if (k != sa && site_valid[k]) begin
          p = pair_index(sa, k);
          cmp_cnt[p] = bump(cmp_cnt[p]);
          if (site_addr[k] == addr) col_cnt[p] = bump(col_cnt[p]);
        end
      end
    end else begin
      a = '0;
      if (sa == sb) begin
        a.prob = pap_pkg::ONE_Q16;
        a.same = 1'b1;
      end else begin
        p = pair_index(sa, sb);
        if (cmp_cnt[p] == 0) a.missing = 1'b1;
        else begin
          a.comparisons = cmp_cnt[p];
          a.collisions = col_cnt[p];
          a.prob = alias_ratio(col_cnt[p], cmp_cnt[p]);
        end
      end
      answers_pending.push_back(a);
    end
  endtask

  // Send one item; valid stays high across back-to-back transfers
  task automatic send_item(pap_pkg::op_t o, int sa, logic [pap_pkg::ADDR_W-1:0] addr, int sb,
                           bit gaps = 1);
    int gap;
    gap = 0;
    if (gaps) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
                    ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    op <= o;
    first_site <= sa[pap_pkg::SITE_W-1:0];
    address <= addr;
    second_site <= sb[pap_pkg::SITE_W-1:0];
    predict_alias(o, sa, addr, sb);
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic go_idle();
    item_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [pap_pkg::ADDR_W-1:0] rand_addr();
    return {$urandom(), $urandom()};
  endfunction

  // Receiver stall pattern: mostly short stalls, now and then a long one
  always @(negedge clk) begin
    if (hold_off) begin
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      result_stall <= 1'b1;
    end else if (!quiet_sink && $urandom_range(0, 39) == 0) begin
      stall_left = $urandom_range(10, 40);
      result_stall <= 1'b1;
    end else if (!quiet_sink && $urandom_range(0, 3) == 0) begin
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // Compare each transfer with the oldest pending answer
  always @(posedge clk) begin
    answer_t e;
    if (!rst && result_valid && !result_stall) begin
      answers_seen++;
      if (answers_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected answer at %0t", $realtime);
      end else begin
        e = answers_pending.pop_front();
        if (pair_comparisons !== e.comparisons || pair_collisions !== e.collisions ||
            probability !== e.prob || same_site !== e.same || not_found !== e.missing) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp cmp=%0d col=%0d p=%0d s=%0b nf=%0b ",
                      "got cmp=%0d col=%0d p=%0d s=%0b nf=%0b"},
                     e.comparisons, e.collisions, e.prob, e.same, e.missing,
                     pair_comparisons, pair_collisions, probability, same_site, not_found);
        end
      end
    end
  end

  // Queries on a fresh block, every bit of both site ids
  task automatic test_empty_queries();
    send_item(pap_pkg::OP_QUERY, 0, '1, 15);
    send_item(pap_pkg::OP_QUERY, 15, '0, 0);
    send_item(pap_pkg::OP_QUERY, 7, '0, 7);
    send_item(pap_pkg::OP_QUERY, 15, '0, 15);
  endtask

  // Address extremes, collisions, same site and uncompared pairs
  task automatic test_directed();
    send_item(pap_pkg::OP_RECORD, 0, '0, 15);
    send_item(pap_pkg::OP_RECORD, 15, '1, 0);
    send_item(pap_pkg::OP_RECORD, 5, '0, 0);
    send_item(pap_pkg::OP_QUERY, 0, '0, 5);
    send_item(pap_pkg::OP_QUERY, 15, '0, 0);
    send_item(pap_pkg::OP_RECORD, 0, 64'hA5A5_5A5A_F0F0_0F0F, 3);
    send_item(pap_pkg::OP_RECORD, 5, 64'hA5A5_5A5A_F0F0_0F0F, 3);
    send_item(pap_pkg::OP_QUERY, 5, '0, 0);
    send_item(pap_pkg::OP_QUERY, 0, '0, 15);
    send_item(pap_pkg::OP_QUERY, 5, '0, 5);
    send_item(pap_pkg::OP_QUERY, 3, '0, 9);
    send_item(pap_pkg::OP_QUERY, 15, '0, 5);
  endtask

  // Mostly small address pool so sites alias often
  task automatic test_random(int n);
    logic [pap_pkg::ADDR_W-1:0] pool [4];
    for (int i = 0; i < 4; i++) pool[i] = rand_addr();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0)
        send_item(pap_pkg::OP_QUERY, $urandom_range(0, 15), rand_addr(),
                  $urandom_range(0, 15));
      else
        send_item(pap_pkg::OP_RECORD, $urandom_range(0, 15),
                  ($urandom_range(0, 3) == 0) ? rand_addr() : pool[$urandom_range(0, 3)],
                  $urandom_range(0, 15));
    end
  endtask

  // Long receiver hold-off while queries keep coming, no sender gaps
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        for (int i = 0; i < 12; i++)
          send_item(pap_pkg::OP_QUERY, $urandom_range(0, 15), '0, $urandom_range(0, 15), 0);
      end
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
    join
  endtask

  // Back-to-back transfers with an always-ready receiver
  task automatic test_streaming();
    quiet_sink = 1'b1;
    for (int i = 0; i < 60; i++)
      send_item(pap_pkg::op_t'($urandom_range(0, 1)), $urandom_range(0, 15), rand_addr(),
                $urandom_range(0, 15), 0);
    quiet_sink = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NSITES; i++) begin
      site_addr[i] = '0;
      site_valid[i] = 1'b0;
    end
    for (int i = 0; i < NPAIRS; i++) begin
      cmp_cnt[i] = '0;
      col_cnt[i] = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_queries();
    test_directed();
    test_backpressure();
    test_random(650);
    test_streaming();
    test_random(80);
    go_idle();
    while (answers_pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && answers_pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
